FILE: sv/oeas_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the one-euro smoother
package oeas_pkg;

   localparam int VALUE_W = 32;
   localparam int RATE_W = 48;
   localparam int CUT_W = 28;
   localparam int STEP_W = 20;
   localparam int ALPHA_W = 24;
   localparam int QUOT_W = 53;
   localparam int STEPS_W = 6;

   localparam logic [1:0] CMD_ADAPT = 2'd0;
   localparam logic [1:0] CMD_EXT = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] REG_MIN_CUTOFF = 3'd0;
   localparam logic [2:0] REG_SPEED_GAIN = 3'd1;
   localparam logic [2:0] REG_DERIV_CUTOFF = 3'd2;
   localparam logic [2:0] REG_MIN_STEP = 3'd3;
   localparam logic [2:0] REG_SPEED_SCALE = 3'd4;

   localparam logic [CUT_W-1:0] CUT_FLOOR = 28'd66;
   localparam logic [CUT_W-1:0] SCALE_FLOOR = 28'd655;
   localparam logic [CUT_W-1:0] CUT_MAX = 28'hFFFFFFF;
   localparam logic [RATE_W-1:0] SPEED_MAX = 48'hFFFFFFFFFFFF;
   localparam logic [QUOT_W-1:0] RATE_MAX = 53'h7FFFFFFFFFFF;
   localparam logic [31:0] US_PER_S = 32'd1000000;
   localparam logic [31:0] TWO_PI_Q12 = 32'd25736;
   localparam logic [63:0] DEN_BIAS = 64'd268435456000000;
   localparam logic [ALPHA_W-1:0] ALPHA_MIN = 24'd17;
   localparam logic [STEPS_W-1:0] RATE_STEPS = 6'd53;
   localparam logic [STEPS_W-1:0] ALPHA_STEPS = 6'd24;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RNUM, ST_RMUL, ST_RDIV, ST_RSAT, ST_KMUL, ST_KGET,
      ST_WLO, ST_WHI, ST_WSUM, ST_ADIV, ST_ALPHA, ST_BPREP, ST_BLO, ST_BHI,
      ST_BSUM, ST_SLO, ST_SHI, ST_SSUM, ST_GLO, ST_GHI, ST_GSUM, ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic [63:0] rem_init;
      logic [QUOT_W-1:0] numer;
      logic [63:0] divisor;
      logic [STEPS_W-1:0] steps;
   } div_req_type;

endpackage

FILE: sv/one_euro_adaptive_smoother.sv
`timescale 1ns / 1ps
// one-euro adaptive smoother, top level with sequencer and shared multiplier
//
// req channel: one word per sample; tuser carries the command (adaptive,
// external cutoff, clear), tdata the sample, step and external cutoff.
// rsp channel: one word per filter command; tdata is the smoothed sample,
// tuser flags a pass-through first sample after a clear.
// csr channel: register writes by index, always ready, take effect at once.
// A clear word gives no result. The first sample after a clear goes straight
// to the emit state and is passed through. A normal sample runs through one
// shared 32x32 multiplier and a bit-serial divider: the rate division takes
// 53 steps and each of the two smoothing factors 24, and req_tready is low
// until the result is handed to the output register.
// The result sits in an output register, so the next sample is taken while
// the receiver stalls; a finished sample waits only if that register is full.
// Reset clears the filter state, restores register defaults and empties the
// output register.
module one_euro_adaptive_smoother (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [79:0] req_tdata,  // sample[31:0], step_us[51:32], external_cutoff[79:52]
   input logic [1:0] req_tuser,   // command[1:0]
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [31:0] rsp_tdata, // smoothed[31:0]
   output logic rsp_tuser,        // bootstrap[0]
   input logic csr_valid,
   output logic csr_ready,
   input logic [2:0] csr_index,
   input logic [27:0] csr_data
);
   import oeas_pkg::*;

   state_type state_ff, state_in;

   logic [CUT_W-1:0] min_cut_ff, gain_ff, dcut_ff, scale_ff;
   logic [STEP_W-1:0] mstep_ff;

   logic primed_ff;
   logic [VALUE_W-1:0] last_sample_ff, last_smooth_ff;
   logic [RATE_W-1:0] last_rate_ff;

   logic [1:0] cmd_ff;
   logic [VALUE_W-1:0] x_ff;
   logic [STEP_W-1:0] dt_ff;
   logic [CUT_W-1:0] ext_ff;

   logic neg_ff;
   logic [31:0] mag_ff;
   logic [34:0] k_ff;
   logic [CUT_W-1:0] fc_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic phase_ff;
   logic [RATE_W-1:0] dx_ff;
   logic bneg_ff;
   logic [RATE_W-1:0] bm_ff;
   logic [RATE_W-1:0] speed_ff;
   logic [63:0] mul_ff, acc_ff;

   logic [VALUE_W-1:0] res_data_ff;
   logic res_boot_ff;
   logic rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_data_ff;
   logic rsp_boot_ff;

   logic req_fire;
   logic [1:0] in_cmd;
   logic [VALUE_W-1:0] in_sample;
   logic [STEP_W-1:0] in_step;
   logic [CUT_W-1:0] in_ext;
   logic [STEP_W-1:0] step_floor, dt_sel;
   logic [VALUE_W:0] diff;
   logic [31:0] mag;
   logic [31:0] mul_a, mul_b;
   div_req_type div_req;
   logic div_done;
   logic [QUOT_W-1:0] div_quot;
   logic [63:0] w_val;
   logic [46:0] rate_sat;
   logic [48:0] old49, tgt49, bdiff, bnew;
   logic [72:0] bsum;
   logic [76:0] wide_sum;
   logic [RATE_W-1:0] rate_mag;
   logic [CUT_W-1:0] min_cut_f, dcut_f, scale_f, ext_f, gain_part;
   logic [CUT_W:0] fc_sum;
   logic emit_go;

   assign in_cmd = req_tuser;
   assign in_sample = req_tdata[31:0];
   assign in_step = req_tdata[51:32];
   assign in_ext = req_tdata[79:52];
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign step_floor = (mstep_ff == '0) ? STEP_W'(1) : mstep_ff;
   assign dt_sel = (in_step < step_floor) ? step_floor : in_step;
   assign diff = {in_sample[VALUE_W-1], in_sample} - {last_sample_ff[VALUE_W-1], last_sample_ff};
   assign mag = diff[VALUE_W] ? 32'(-diff) : diff[31:0];

   assign min_cut_f = (min_cut_ff < CUT_FLOOR) ? CUT_FLOOR : min_cut_ff;
   assign dcut_f = (dcut_ff < CUT_FLOOR) ? CUT_FLOOR : dcut_ff;
   assign scale_f = (scale_ff < SCALE_FLOOR) ? SCALE_FLOOR : scale_ff;
   assign ext_f = (ext_ff < CUT_FLOOR) ? CUT_FLOOR : ext_ff;

   assign w_val = acc_ff + {mul_ff[31:0], 32'd0};
   assign rate_sat = (div_quot > RATE_MAX) ? RATE_MAX[46:0] : div_quot[46:0];

   assign old49 = phase_ff ? {{17{last_smooth_ff[VALUE_W-1]}}, last_smooth_ff}
                           : {last_rate_ff[RATE_W-1], last_rate_ff};
   assign tgt49 = phase_ff ? {{17{x_ff[VALUE_W-1]}}, x_ff} : {dx_ff[RATE_W-1], dx_ff};
   assign bdiff = tgt49 - old49;
   assign bsum = {mul_ff[40:0], 32'd0} + {9'd0, acc_ff} + 73'h800000;
   assign bnew = bneg_ff ? old49 - {1'b0, bsum[71:24]} : old49 + {1'b0, bsum[71:24]};

   assign wide_sum = {mul_ff[44:0], 32'd0} + {13'd0, acc_ff};
   assign rate_mag = last_rate_ff[RATE_W-1] ? -last_rate_ff : last_rate_ff;
   assign gain_part = (wide_sum[76:64] != '0 || wide_sum[63:16] > {20'd0, CUT_MAX})
                      ? CUT_MAX : wide_sum[43:16];
   assign fc_sum = {1'b0, min_cut_f} + {1'b0, gain_part};

   assign emit_go = !rsp_valid_ff || rsp_tready;

   oeas_divider u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .done(div_done),
      .quot(div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (in_cmd == CMD_ADAPT || in_cmd == CMD_EXT) begin
                  state_in = primed_ff ? ST_RNUM : ST_EMIT;
               end
            end
         end
         ST_RNUM: state_in = ST_RMUL;
         ST_RMUL: state_in = ST_RDIV;
         ST_RDIV: if (div_done) state_in = ST_RSAT;
         ST_RSAT: state_in = ST_KMUL;
         ST_KMUL: state_in = ST_KGET;
         ST_KGET: state_in = ST_WLO;
         ST_WLO: state_in = ST_WHI;
         ST_WHI: state_in = ST_WSUM;
         ST_WSUM: state_in = ST_ADIV;
         ST_ADIV: if (div_done) state_in = ST_ALPHA;
         ST_ALPHA: state_in = ST_BPREP;
         ST_BPREP: state_in = ST_BLO;
         ST_BLO: state_in = ST_BHI;
         ST_BHI: state_in = ST_BSUM;
         ST_BSUM: begin
            if (phase_ff) begin
               state_in = ST_EMIT;
            end else if (cmd_ff == CMD_ADAPT) begin
               state_in = ST_SLO;
            end else begin
               state_in = ST_WLO;
            end
         end
         ST_SLO: state_in = ST_SHI;
         ST_SHI: state_in = ST_SSUM;
         ST_SSUM: state_in = ST_GLO;
         ST_GLO: state_in = ST_GHI;
         ST_GHI: state_in = ST_GSUM;
         ST_GSUM: state_in = ST_WLO;
         ST_EMIT: if (emit_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: multiplier operands, divider requests, ready
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_req = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_RNUM: begin
            mul_a = mag_ff;
            mul_b = US_PER_S;
         end
         ST_RMUL: begin
            div_req.start = 1'b1;
            div_req.numer = mul_ff[QUOT_W-1:0];
            div_req.divisor = {44'd0, dt_ff};
            div_req.steps = RATE_STEPS;
         end
         ST_KMUL: begin
            mul_a = {12'd0, dt_ff};
            mul_b = TWO_PI_Q12;
         end
         ST_WLO: begin
            mul_a = k_ff[31:0];
            mul_b = {4'd0, fc_ff};
         end
         ST_WHI: begin
            mul_a = {29'd0, k_ff[34:32]};
            mul_b = {4'd0, fc_ff};
         end
         ST_WSUM: begin
            div_req.start = 1'b1;
            div_req.rem_init = w_val;
            div_req.divisor = w_val + DEN_BIAS;
            div_req.steps = ALPHA_STEPS;
         end
         ST_BLO: begin
            mul_a = bm_ff[31:0];
            mul_b = {8'd0, alpha_ff};
         end
         ST_BHI: begin
            mul_a = {16'd0, bm_ff[47:32]};
            mul_b = {8'd0, alpha_ff};
         end
         ST_SLO: begin
            mul_a = rate_mag[31:0];
            mul_b = {4'd0, scale_f};
         end
         ST_SHI: begin
            mul_a = {16'd0, rate_mag[47:32]};
            mul_b = {4'd0, scale_f};
         end
         ST_GLO: begin
            mul_a = speed_ff[31:0];
            mul_b = {4'd0, gain_ff};
         end
         ST_GHI: begin
            mul_a = {16'd0, speed_ff[47:32]};
            mul_b = {4'd0, gain_ff};
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         primed_ff <= 1'b0;
         last_sample_ff <= '0;
         last_smooth_ff <= '0;
         last_rate_ff <= '0;
         rsp_valid_ff <= 1'b0;
         min_cut_ff <= 28'd65536;
         gain_ff <= 28'd459;
         dcut_ff <= 28'd65536;
         mstep_ff <= 20'd1;
         scale_ff <= 28'd65536;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_MIN_CUTOFF: min_cut_ff <= csr_data;
               REG_SPEED_GAIN: gain_ff <= csr_data;
               REG_DERIV_CUTOFF: dcut_ff <= csr_data;
               REG_MIN_STEP: mstep_ff <= csr_data[STEP_W-1:0];
               REG_SPEED_SCALE: scale_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req_fire) begin
            if (in_cmd == CMD_CLEAR) begin
               primed_ff <= 1'b0;
               last_sample_ff <= '0;
               last_smooth_ff <= '0;
               last_rate_ff <= '0;
            end else if (in_cmd == CMD_ADAPT || in_cmd == CMD_EXT) begin
               primed_ff <= 1'b1;
               last_sample_ff <= in_sample;
               if (!primed_ff) begin
                  last_smooth_ff <= in_sample;
                  last_rate_ff <= '0;
               end
            end
         end
         if (state_ff == ST_BSUM) begin
            if (phase_ff) begin
               last_smooth_ff <= bnew[VALUE_W-1:0];
            end else begin
               last_rate_ff <= bnew[RATE_W-1:0];
            end
         end
         if (state_ff == ST_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (state_ff == ST_WHI || state_ff == ST_BHI || state_ff == ST_SHI ||
          state_ff == ST_GHI) begin
         acc_ff <= mul_ff;
      end
      if (state_ff == ST_IDLE && req_fire) begin
         cmd_ff <= in_cmd;
         x_ff <= in_sample;
         dt_ff <= dt_sel;
         ext_ff <= in_ext;
         neg_ff <= diff[VALUE_W];
         mag_ff <= mag;
         res_data_ff <= in_sample;
         res_boot_ff <= 1'b1;
      end
      if (state_ff == ST_RSAT) begin
         dx_ff <= neg_ff ? -{1'b0, rate_sat} : {1'b0, rate_sat};
      end
      if (state_ff == ST_KGET) begin
         k_ff <= mul_ff[34:0];
         fc_ff <= dcut_f;
         phase_ff <= 1'b0;
      end
      if (state_ff == ST_ALPHA) begin
         alpha_ff <= (div_quot[ALPHA_W-1:0] < ALPHA_MIN) ? ALPHA_MIN : div_quot[ALPHA_W-1:0];
      end
      if (state_ff == ST_BPREP) begin
         bneg_ff <= bdiff[48];
         bm_ff <= bdiff[48] ? RATE_W'(-bdiff) : bdiff[RATE_W-1:0];
      end
      if (state_ff == ST_BSUM) begin
         if (phase_ff) begin
            res_data_ff <= bnew[VALUE_W-1:0];
            res_boot_ff <= 1'b0;
         end else if (cmd_ff != CMD_ADAPT) begin
            fc_ff <= ext_f;
            phase_ff <= 1'b1;
         end
      end
      if (state_ff == ST_SSUM) begin
         speed_ff <= (wide_sum[76:64] != '0) ? SPEED_MAX : wide_sum[63:16];
      end
      if (state_ff == ST_GSUM) begin
         fc_ff <= fc_sum[CUT_W] ? CUT_MAX : fc_sum[CUT_W-1:0];
         phase_ff <= 1'b1;
      end
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_data_ff <= res_data_ff;
         rsp_boot_ff <= res_boot_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_boot_ff;

endmodule

FILE: sv/oeas_divider.sv
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
module oeas_divider (
   input logic clock,
   input logic reset,
   input oeas_pkg::div_req_type req,
   output logic done,
   output logic [oeas_pkg::QUOT_W-1:0] quot
);
   import oeas_pkg::*;

   logic busy_ff;
   logic done_ff;
   logic [STEPS_W-1:0] cnt_ff;
   logic [63:0] rem_ff;
   logic [QUOT_W-1:0] numer_ff;
   logic [63:0] div_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [63:0] shifted;
   logic ge;

   assign shifted = {rem_ff[62:0], numer_ff[QUOT_W-1]};
   assign ge = shifted >= div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEPS_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.rem_init;
         numer_ff <= req.numer;
         div_ff <= req.divisor;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? shifted - div_ff : shifted;
         numer_ff <= {numer_ff[QUOT_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: sv/oeas_checker.sv
`timescale 1ns / 1ps
// port-level checks for the one-euro smoother
module oeas_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [1:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic rsp_tuser
);
   import oeas_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // a clear word leaves the block ready
   a_clear_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_CLEAR |=> req_tready)
      else $error("not ready after clear");

   // a filter word keeps the block busy for the next cycle
   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_ADAPT || req_tuser == CMD_EXT)
      |=> !req_tready)
      else $error("ready right after a filter word");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind one_euro_adaptive_smoother oeas_checker u_oeas_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// testbench for one_euro_adaptive_smoother: predicts each word and checks the result stream
module tb;
   import oeas_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES = 800;
   localparam logic [63:0] RATE_LIMIT = 64'h7FFF_FFFF_FFFF;
   localparam logic [63:0] SPEED_LIMIT = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [1:0] cmd;
      logic [31:0] sample;
      logic [19:0] step;
      logic [27:0] ext;
   } sample_word_type;

   typedef struct {
      logic [31:0] smoothed;
      logic bootstrap;
   } smooth_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [79:0] req_tdata = '0;  // sample[31:0], step_us[51:32], external_cutoff[79:52]
   logic [1:0] req_tuser = '0;   // command[1:0]
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;       // smoothed[31:0]
   logic rsp_tuser;              // bootstrap[0]
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [27:0] csr_data = '0;

   one_euro_adaptive_smoother DUT (.*);

   sample_word_type sample_q[$];
   smooth_word_type smoothed_q[$];
   int tx_idle_pct = 26;
   int rx_idle_pct = 68;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_cnt = 0;
   int fail_cnt = 0;
   int cycles = 0;
   logic req_took = 0;
   logic [31:0] walk_pos = 0;

   // predictor state and registers
   logic [63:0] min_cutoff = 65536, speed_gain = 459, deriv_cutoff = 65536;
   logic [63:0] min_step = 1, speed_scale = 65536;
   logic primed = 0;
   longint last_sample = 0, last_smoothed = 0, last_rate = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] at_least(logic [63:0] v, logic [63:0] lo);
      return v < lo ? lo : v;
   endfunction

   function automatic logic [63:0] alpha_from(logic [63:0] fc, logic [63:0] dt);
      logic [63:0] w, den, r, q;
      w = fc * dt * 64'(TWO_PI_Q12);
      den = w + DEN_BIAS;
      r = w;
      q = 0;
      for (int i = 0; i < ALPHA_W; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'd1;
         end
      end
      return q < 64'(ALPHA_MIN) ? 64'(ALPHA_MIN) : q;
   endfunction

   function automatic logic [63:0] round_scale(logic [63:0] m, logic [63:0] a);
      logic [63:0] p0, p1;
      p0 = (m & 64'hFFFF_FFFF) * a + (64'd1 << (ALPHA_W - 1));
      p1 = (m >> 32) * a;
      return (p1 << (32 - ALPHA_W)) + (p0 >> ALPHA_W);
   endfunction

   function automatic longint mix(longint old, longint target, logic [63:0] a);
      logic [63:0] u;
      if (target >= old)
         u = $unsigned(old) + round_scale($unsigned(target) - $unsigned(old), a);
      else
         u = $unsigned(old) - round_scale($unsigned(old) - $unsigned(target), a);
      return longint'(u);
   endfunction

   function automatic logic [63:0] q16_mul_sat(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] lim);
      logic [63:0] p;
      if (a == 0 || b == 0) return 0;
      if (a > 64'hFFFF_FFFF_FFFF_FFFF / b) return lim;
      p = (a * b) >> 16;
      return p > lim ? lim : p;
   endfunction

   function automatic longint rate_from(longint diff, logic [63:0] dt);
      logic [63:0] mag, q1, q;
      mag = diff < 0 ? 64'd0 - $unsigned(diff) : $unsigned(diff);
      q1 = mag / dt;
      if (q1 > RATE_LIMIT / 64'd1000000) begin
         q = RATE_LIMIT;
      end else begin
         q = q1 * 64'd1000000 + ((mag % dt) * 64'd1000000) / dt;
         if (q > RATE_LIMIT) q = RATE_LIMIT;
      end
      return diff < 0 ? -longint'(q) : longint'(q);
   endfunction

   task automatic smooth_predict(input sample_word_type s);
      smooth_word_type o;
      longint x, y;
      logic [63:0] dt, fc, mag, speed;
      x = longint'($signed(s.sample));
      if (s.cmd == CMD_CLEAR) begin
         primed = 0;
         last_sample = 0;
         last_smoothed = 0;
         last_rate = 0;
      end else if (s.cmd != CMD_UNUSED) begin
         if (!primed) begin
            primed = 1;
            last_sample = x;
            last_smoothed = x;
            last_rate = 0;
            o.smoothed = s.sample;
            o.bootstrap = 1;
         end else begin
            dt = at_least(64'(s.step), at_least(min_step, 1));
            last_rate = mix(last_rate, rate_from(x - last_sample, dt),
                            alpha_from(at_least(deriv_cutoff, 64'(CUT_FLOOR)), dt));
            last_sample = x;
            if (s.cmd == CMD_ADAPT) begin
               mag = last_rate < 0 ? 64'd0 - $unsigned(last_rate) : $unsigned(last_rate);
               speed = q16_mul_sat(mag, at_least(speed_scale, 64'(SCALE_FLOOR)), SPEED_LIMIT);
               fc = at_least(min_cutoff, 64'(CUT_FLOOR))
                    + q16_mul_sat(speed, speed_gain, 64'(CUT_MAX));
               if (fc > 64'(CUT_MAX)) fc = 64'(CUT_MAX);
            end else begin
               fc = at_least(64'(s.ext), 64'(CUT_FLOOR));
            end
            y = mix(last_smoothed, x, alpha_from(fc, dt));
            last_smoothed = y;
            o.smoothed = y[31:0];
            o.bootstrap = 0;
         end
         smoothed_q.push_back(o);
      end
   endtask

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_took) begin
         if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_tvalid <= 1;
            req_tdata <= {sample_q[0].ext, sample_q[0].step, sample_q[0].sample};
            req_tuser <= sample_q[0].cmd;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // result receiver with occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_cnt > 0) begin
         rsp_tready <= 0;
         hold_cnt <= hold_cnt - 1;
      end else if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_cnt <= HOLD_CYCLES;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(99) >= rx_idle_pct;
      end
   end

   // accepted words, register writes and result checks
   always @(posedge clock) begin
      smooth_word_type e;
      sample_word_type s;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      req_took <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         void'(sample_q.pop_front());
         s.cmd = req_tuser;
         s.sample = req_tdata[31:0];
         s.step = req_tdata[51:32];
         s.ext = req_tdata[79:52];
         smooth_predict(s);
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_MIN_CUTOFF: min_cutoff = 64'(csr_data);
            REG_SPEED_GAIN: speed_gain = 64'(csr_data);
            REG_DERIV_CUTOFF: deriv_cutoff = 64'(csr_data);
            REG_MIN_STEP: min_step = 64'(csr_data[19:0]);
            REG_SPEED_SCALE: speed_scale = 64'(csr_data);
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (smoothed_q.size() == 0) begin
            $error("unexpected result smoothed=%h bootstrap=%b", rsp_tdata, rsp_tuser);
            fail_cnt++;
         end else begin
            e = smoothed_q.pop_front();
            if (rsp_tdata !== e.smoothed) begin
               $error("smoothed expected %h actual %h", e.smoothed, rsp_tdata);
               fail_cnt++;
            end
            if (rsp_tuser !== e.bootstrap) begin
               $error("bootstrap expected %b actual %b", e.bootstrap, rsp_tuser);
               fail_cnt++;
            end
         end
      end
   end

   task automatic add_word(logic [1:0] cmd, logic [31:0] sample, logic [19:0] step,
                           logic [27:0] ext);
      sample_word_type s;
      s.cmd = cmd;
      s.sample = sample;
      s.step = step;
      s.ext = ext;
      sample_q.push_back(s);
   endtask

   task automatic add_random(int n);
      int r;
      logic [1:0] cmd;
      logic [19:0] step;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 3) cmd = CMD_CLEAR;
         else if (r < 4) cmd = CMD_UNUSED;
         else if (r < 55) cmd = CMD_ADAPT;
         else cmd = CMD_EXT;
         r = $urandom_range(99);
         if (r < 8) walk_pos = $urandom;
         else if (r < 60) walk_pos = walk_pos + 32'($signed($urandom_range(8000)) - 4000);
         else walk_pos = walk_pos + 32'($signed($urandom_range(2000000)) - 1000000);
         r = $urandom_range(99);
         if (r < 5) step = '0;
         else if (r < 15) step = 20'($urandom_range(1000000));
         else if (r < 18) step = 20'd1000000;
         else step = 20'($urandom_range(20000, 100));
         add_word(cmd, walk_pos, step,
                  $urandom_range(1) ? 28'($urandom) : 28'($urandom_range(2000000)));
      end
   endtask

   task automatic csr_write(logic [2:0] idx, logic [27:0] val);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic wait_drained();
      while (!(sample_q.size() == 0 && !req_tvalid && smoothed_q.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_all(logic [27:0] mc, logic [27:0] sg, logic [27:0] dc,
                            logic [19:0] ms, logic [27:0] ss);
      wait_drained();
      csr_write(REG_MIN_CUTOFF, mc);
      csr_write(REG_SPEED_GAIN, sg);
      csr_write(REG_DERIV_CUTOFF, dc);
      csr_write(REG_MIN_STEP, 28'(ms));
      csr_write(REG_SPEED_SCALE, ss);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: bootstrap, extremes, each command
      add_word(CMD_ADAPT, 32'h8000_0000, 20'd0, 28'd0);
      add_word(CMD_ADAPT, 32'h7FFF_FFFF, 20'd0, 28'd0);
      add_word(CMD_ADAPT, 32'h8000_0000, 20'd1, 28'd0);
      add_word(CMD_EXT, 32'h7FFF_FFFF, 20'd1000000, 28'hFFFFFFF);
      add_word(CMD_EXT, 32'h0000_0000, 20'd1, 28'd0);
      add_word(CMD_EXT, 32'h0001_0000, 20'd500, 28'd65);
      add_word(CMD_UNUSED, 32'h1234_5678, 20'd10, 28'd100);
      add_word(CMD_ADAPT, 32'hFFFF_FFFF, 20'hFFFFF, 28'hFFFFFFF);
      add_word(CMD_CLEAR, 32'h0, 20'd0, 28'd0);
      add_word(CMD_EXT, 32'h7FFF_FFFF, 20'd1000, 28'd66);
      add_word(CMD_EXT, 32'h8000_0000, 20'd1000000, 28'hFFFFFFF);
      add_word(CMD_ADAPT, 32'h0000_0000, 20'd0, 28'd0);
      add_word(CMD_CLEAR, 32'hFFFF_FFFF, 20'hFFFFF, 28'hFFFFFFF);
      add_word(CMD_CLEAR, 32'h0, 20'd0, 28'd0);
      add_word(CMD_ADAPT, 32'h0000_0001, 20'd100, 28'd0);
      add_word(CMD_ADAPT, 32'h0000_0001, 20'd100, 28'd0);
      add_random(400);

      write_all(28'd0, 28'hFFFFFFF, 28'hFFFFFFF, 20'd0, 28'd0);
      add_random(150);
      hold_ticket = hold_ticket + 1;
      add_random(250);

      write_all(28'hFFFFFFF, 28'hFFFFFFF, 28'd66, 20'd1000000, 28'hFFFFFFF);
      tx_idle_pct = 68;
      rx_idle_pct = 26;
      add_random(300);

      write_all(28'($urandom_range(1000000, 66)), 28'($urandom_range(200000)),
                28'($urandom_range(500000, 66)), 20'($urandom_range(2000, 1)),
                28'($urandom_range(300000, 655)));
      add_random(400);

      write_all(28'd65536, 28'd4590, 28'd65536, 20'd1, 28'd65536);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      add_random(500);

      wait_drained();
      if (fail_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
